[sv/spta_pkg.sv]
package spta_pkg;

    // input item kinds (s_tuser)
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TERM  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    // result status codes (m_tuser)
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FLUSH_RD,
        ST_FLUSH_CMP,
        ST_EMIT
    } spta_state_t;

endpackage

[sv/spta_ram.sv]
module spta_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/spta_ctrl.sv]
module spta_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int EXP_BITS    = 8,
    parameter int COEF_BITS   = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            in_kind,
    input  logic [COEF_BITS-1:0]                  in_coef,
    input  logic [3*EXP_BITS-1:0]                 in_exps,
    output logic                                  ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]        ram_waddr,
    output logic [COEF_BITS+3*EXP_BITS:0]         ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]        ram_raddr,
    input  logic [COEF_BITS+3*EXP_BITS:0]         ram_rdata,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [COEF_BITS:0]                    res_coef,
    output logic [3*EXP_BITS-1:0]                 res_exps,
    output logic [1:0]                            res_status,
    output logic                                  res_last
);

    import spta_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = 3 * EXP_BITS;
    localparam int EW = COEF_BITS + XW + 1;

    spta_state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [1:0]           kind_reg, kind_next;
    logic [COEF_BITS-1:0] coef_reg, coef_next;
    logic [XW-1:0]        exps_reg, exps_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [COEF_BITS:0]   rcoef_reg, rcoef_next;
    logic [XW-1:0]        rexps_reg, rexps_next;
    logic [1:0]           rstatus_reg, rstatus_next;

    logic [COEF_BITS-1:0] rd_coef;
    logic [XW-1:0]        rd_exps;
    logic                 rd_used;
    logic                 accept;
    logic                 table_full;
    logic                 table_empty;
    logic                 at_end;
    logic                 hit;
    logic                 fstall;
    logic                 advance;
    logic [COEF_BITS:0]   sum;

    assign rd_coef = ram_rdata[COEF_BITS-1:0];
    assign rd_exps = ram_rdata[COEF_BITS+XW-1:COEF_BITS];
    assign rd_used = ram_rdata[EW-1];

    assign accept      = in_valid && in_ready;
    assign table_full  = (count_reg == CW'(TABLE_DEPTH));
    assign table_empty = (count_reg == '0);
    assign at_end      = (CW'(idx_reg) == count_reg - CW'(1));
    assign hit         = !rd_used && (rd_exps == exps_reg);
    // a pending flush word must leave before the next unconsumed one replaces it
    assign fstall      = !rd_used && pend_valid_reg && !res_ready;
    assign advance     = (state_reg == ST_SCAN_CMP) ||
                         (state_reg == ST_FLUSH_CMP && !fstall);
    assign sum         = {coef_reg[COEF_BITS-1], coef_reg} + {rd_coef[COEF_BITS-1], rd_coef};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_kind)
                        KIND_LOAD:  state_next = table_full ? ST_EMIT : ST_IDLE;
                        KIND_TERM:  state_next = table_empty ? ST_EMIT : ST_SCAN_RD;
                        KIND_FLUSH: state_next = table_empty ? ST_EMIT : ST_FLUSH_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (hit || at_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_FLUSH_RD: state_next = ST_FLUSH_CMP;
            ST_FLUSH_CMP: begin
                if (!fstall && at_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {1'b1, rd_exps, rd_coef};
        ram_raddr = advance ? idx_reg + AW'(1) : idx_reg;
        res_valid = 1'b0;
        res_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = {1'b0, in_exps, in_coef};
                ram_we    = accept && (in_kind == KIND_LOAD) && !table_full;
            end
            ST_SCAN_CMP: ram_we = hit;
            ST_FLUSH_CMP: res_valid = !rd_used && pend_valid_reg;
            ST_EMIT: begin
                res_valid = 1'b1;
                res_last  = 1'b1;
            end
            default: ;
        endcase
    end

    assign res_coef   = rcoef_reg;
    assign res_exps   = rexps_reg;
    assign res_status = rstatus_reg;

    // datapath registers
    always_comb begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        coef_next       = coef_reg;
        exps_next       = exps_reg;
        pend_valid_next = pend_valid_reg;
        rcoef_next      = rcoef_reg;
        rexps_next      = rexps_reg;
        rstatus_next    = rstatus_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next       = in_kind;
                    coef_next       = in_coef;
                    exps_next       = in_exps;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    rcoef_next      = {in_coef[COEF_BITS-1], in_coef};
                    rexps_next      = in_exps;
                    rstatus_next    = STATUS_OK;
                    if (in_kind == KIND_LOAD) begin
                        if (table_full) begin
                            rcoef_next   = '0;
                            rexps_next   = '0;
                            rstatus_next = STATUS_FULL;
                        end else begin
                            count_next = count_reg + CW'(1);
                        end
                    end else if (in_kind == KIND_FLUSH) begin
                        rcoef_next   = '0;
                        rexps_next   = '0;
                        rstatus_next = STATUS_EMPTY;
                    end
                end
            end
            ST_SCAN_CMP: begin
                if (hit) begin
                    rcoef_next = sum;
                end else if (!at_end) begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_FLUSH_CMP: begin
                if (!fstall) begin
                    if (!rd_used) begin
                        rcoef_next      = {rd_coef[COEF_BITS-1], rd_coef};
                        rexps_next      = rd_exps;
                        rstatus_next    = STATUS_OK;
                        pend_valid_next = 1'b1;
                    end
                    if (at_end) begin
                        if (!pend_valid_reg && rd_used) begin
                            rcoef_next   = '0;
                            rexps_next   = '0;
                            rstatus_next = STATUS_EMPTY;
                        end
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (res_ready && kind_reg == KIND_FLUSH) begin
                    count_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg        <= idx_next;
        kind_reg       <= kind_next;
        coef_reg       <= coef_next;
        exps_reg       <= exps_next;
        pend_valid_reg <= pend_valid_next;
        rcoef_reg      <= rcoef_next;
        rexps_reg      <= rexps_next;
        rstatus_reg    <= rstatus_next;
    end

endmodule

[sv/sparse_polynomial_term_adder.sv]
// sparse polynomial term adder
// s_ channel takes words of three kinds (s_tuser): load a term of the second
// polynomial into the term table, a term of the first polynomial, or flush.
// m_ channel returns result terms; m_tuser carries the status, m_tlast marks
// the final result of each input word.
// a load gives no result unless the table is full.
// a first-polynomial term walks the table one entry per cycle through the
// single read port of the table memory: its result enters the output register
// on the same edge that s_tready returns.
// a flush walks all loaded entries the same way and emits at most one result
// per cycle while the receiver keeps m_tready high.
// one item is in work at a time; s_tready is high only while idle.
// the output register holds a finished result while the next word is taken;
// with m_tready low a flush walk pauses before its next result and nothing is lost.
// reset clears the control state and empties the table; table contents need
// no clearing since only loaded entries are ever examined.
module sparse_polynomial_term_adder #(
    parameter int TABLE_DEPTH = 64,
    parameter int EXP_BITS    = 8,
    parameter int COEF_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // coefficient, exp_x, exp_y, exp_z, zero fill
    input  logic [((COEF_BITS+3*EXP_BITS+7)/8)*8-1:0]   s_tdata,
    // kind
    input  logic [1:0]                                   s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // sum_coefficient, out_exp_x, out_exp_y, out_exp_z, zero fill
    output logic [((COEF_BITS+1+3*EXP_BITS+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]                                   m_tuser,
    output logic                                         m_tlast
);

    import spta_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int XW  = 3 * EXP_BITS;
    localparam int EW  = COEF_BITS + XW + 1;
    localparam int MDW = ((COEF_BITS + 1 + XW + 7) / 8) * 8;
    localparam int PADW = MDW - (COEF_BITS + 1 + XW);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic                 res_valid;
    logic                 res_ready;
    logic [COEF_BITS:0]   res_coef;
    logic [XW-1:0]        res_exps;
    logic [1:0]           res_status;
    logic                 res_last;

    logic                 m_valid_reg, m_valid_next;
    logic [COEF_BITS:0]   m_coef_reg;
    logic [XW-1:0]        m_exps_reg;
    logic [1:0]           m_status_reg;
    logic                 m_last_reg;

    spta_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spta_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .EXP_BITS    (EXP_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_coef    (s_tdata[COEF_BITS-1:0]),
        .in_exps    (s_tdata[COEF_BITS+XW-1:COEF_BITS]),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_coef   (res_coef),
        .res_exps   (res_exps),
        .res_status (res_status),
        .res_last   (res_last)
    );

    // output register takes a new word when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            m_coef_reg   <= res_coef;
            m_exps_reg   <= res_exps;
            m_status_reg <= res_status;
            m_last_reg   <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, m_exps_reg, m_coef_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
